// ===== hdl/thp_pkg.sv =====
// shared types, constants and helper functions of the sensor compensation unit
// used by every module of the block except thp_mul64, no dependencies

package thp_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_TRIM    = 3'd0,
      CSR_PRESS_TRIM_A = 3'd1,
      CSR_PRESS_TRIM_B = 3'd2,
      CSR_PRESS_TRIM_C = 3'd3,
      CSR_HUM_TRIM_A   = 3'd4,
      CSR_HUM_TRIM_B   = 3'd5
   } thp_csr_type;

   // pipeline depths
   localparam int TEMP_LAT  = 5;
   localparam int DIV_STEPS = 64;
   localparam int PRESS_LAT = 15 + DIV_STEPS;
   localparam int HUM_LAT   = 10;
   localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

   // formula constants
   localparam logic [63:0] TFINE_OFS_P  = 64'd128000;
   localparam logic [63:0] PRESS_BASE   = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE  = 64'd3125;
   localparam logic [31:0] TFINE_OFS_H  = 32'd76800;
   localparam logic [31:0] HUM_MAX      = 32'd419430400;
   localparam logic [31:0] HUM_BIAS_Y   = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_X  = 32'd16384;
   localparam logic [31:0] HUM_BIAS_H3  = 32'd32768;
   localparam logic [31:0] HUM_ROUND_Y  = 32'd8192;
   localparam logic [31:0] TEMP_ROUND   = 32'd128;
   localparam logic [63:0] PRESS_ONE_47 = 64'h0000_8000_0000_0000;

   // trim words split out of the configuration registers
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [11:0] h4;
      logic [11:0] h5;
      logic [7:0]  h6;
   } thp_trim_type;

   function automatic logic [31:0] sx32_16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] sx32_12(input logic [11:0] x);
      return {{20{x[11]}}, x};
   endfunction

   function automatic logic [31:0] sx32_8(input logic [7:0] x);
      return {{24{x[7]}}, x};
   endfunction

   function automatic logic [63:0] sx64_16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx64_32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
      return 64'($signed(x) >>> n);
   endfunction

endpackage

// ===== hdl/thp_mul64.sv =====
// two-stage 64 x 64 multiplier keeping the low 64 bits of the product
// built from three 32 x 32 partial products, no dependencies

module thp_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] pp0_ff;
   logic [31:0] pp1_ff;
   logic [31:0] pp2_ff;
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff <= 64'(a[31:0]) * 64'(b[31:0]);
         pp1_ff <= 32'(a[31:0] * b[63:32]);
         pp2_ff <= 32'(a[63:32] * b[31:0]);
         p_ff   <= pp0_ff + {32'(pp1_ff + pp2_ff), 32'd0};
      end
   end

   assign p = p_ff;

endmodule

// ===== hdl/thp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// 64-bit dividend by 31-bit divisor, depends on thp_pkg

module thp_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [30:0] den,
   input  logic [1:0]  side,
   output logic [63:0] quo,
   output logic [1:0]  side_out
);

   localparam int STEPS = thp_pkg::DIV_STEPS;

   // nq holds remaining dividend bits on top, quotient bits shifting in below
   logic [30:0] rem_ff  [STEPS];
   logic [63:0] nq_ff   [STEPS];
   logic [30:0] den_ff  [STEPS];
   logic [1:0]  side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [30:0] rem_prev;
      logic [63:0] nq_prev;
      logic [30:0] den_prev;
      logic [1:0]  side_prev;
      logic [31:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign nq_prev   = num;
         assign den_prev  = den;
         assign side_prev = side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign nq_prev   = nq_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = {rem_prev, nq_prev[63]};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? 31'(trial - {1'b0, den_prev}) : trial[30:0];
            nq_ff[k]   <= {nq_prev[62:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign quo      = nq_ff[STEPS-1];
   assign side_out = side_ff[STEPS-1];

endmodule

// ===== hdl/thp_temp.sv =====
// temperature stages: fine temperature, centidegree result and the
// offsets that feed the pressure and humidity paths, depends on thp_pkg

module thp_temp (
   input  logic                clock,
   input  logic                en,
   input  thp_pkg::thp_trim_type trim,
   input  logic [19:0]         raw_temp,
   input  logic [19:0]         raw_press,
   input  logic [15:0]         raw_hum,
   output logic [31:0]         temp_centideg,
   output logic [63:0]         press_ofs,
   output logic [31:0]         hum_ofs,
   output logic [19:0]         raw_press_d,
   output logic [15:0]         raw_hum_d
);

   localparam int LAT = thp_pkg::TEMP_LAT;

   logic [31:0] a_ff;
   logic [31:0] d_ff;
   logic [31:0] m1_ff;
   logic [31:0] dd_ff;
   logic [31:0] v1_ff;
   logic [31:0] e_ff;
   logic [31:0] tf_ff;
   logic [31:0] temp_ff;
   logic [63:0] pofs_ff;
   logic [31:0] hofs_ff;
   logic [19:0] ap_ff [LAT];
   logic [15:0] ah_ff [LAT];
   logic [31:0] t1z;

   assign t1z = {16'd0, trim.t1};

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= {15'd0, raw_temp[19:3]} - {t1z[30:0], 1'b0};
         d_ff    <= {16'd0, raw_temp[19:4]} - t1z;
         m1_ff   <= a_ff * thp_pkg::sx32_16(trim.t2);
         dd_ff   <= d_ff * d_ff;
         v1_ff   <= thp_pkg::asr32(m1_ff, 11);
         e_ff    <= thp_pkg::asr32(dd_ff, 12) * thp_pkg::sx32_16(trim.t3);
         tf_ff   <= v1_ff + thp_pkg::asr32(e_ff, 14);
         temp_ff <= thp_pkg::asr32(tf_ff * 32'd5 + thp_pkg::TEMP_ROUND, 8);
         pofs_ff <= thp_pkg::sx64_32(tf_ff) - thp_pkg::TFINE_OFS_P;
         hofs_ff <= tf_ff - thp_pkg::TFINE_OFS_H;
         ap_ff[0] <= raw_press;
         ah_ff[0] <= raw_hum;
         for (int i = 1; i < LAT; i++) begin
            ap_ff[i] <= ap_ff[i-1];
            ah_ff[i] <= ah_ff[i-1];
         end
      end
   end

   assign temp_centideg = temp_ff;
   assign press_ofs     = pofs_ff;
   assign hum_ofs       = hofs_ff;
   assign raw_press_d   = ap_ff[LAT-1];
   assign raw_hum_d     = ah_ff[LAT-1];

endmodule

// ===== hdl/thp_press.sv =====
// pressure stages: 64-bit polynomial terms, signed division and final
// correction, depends on thp_pkg, thp_mul64 and thp_div

module thp_press (
   input  logic                  clock,
   input  logic                  en,
   input  thp_pkg::thp_trim_type trim,
   input  logic [63:0]           press_ofs,
   input  logic [19:0]           raw_press,
   output logic [31:0]           press_q24_8,
   output logic                  press_div_zero
);

   logic [63:0] p1z, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

   assign p1z = {48'd0, trim.p1};
   assign p2x = thp_pkg::sx64_16(trim.p2);
   assign p3x = thp_pkg::sx64_16(trim.p3);
   assign p4x = thp_pkg::sx64_16(trim.p4);
   assign p5x = thp_pkg::sx64_16(trim.p5);
   assign p6x = thp_pkg::sx64_16(trim.p6);
   assign p7x = thp_pkg::sx64_16(trim.p7);
   assign p8x = thp_pkg::sx64_16(trim.p8);
   assign p9x = thp_pkg::sx64_16(trim.p9);

   // first products of the offset
   logic [63:0] sq, u5, u2;
   thp_mul64 u_mul_sq (.clock(clock), .en(en), .a(press_ofs), .b(press_ofs), .p(sq));
   thp_mul64 u_mul_u5 (.clock(clock), .en(en), .a(press_ofs), .b(p5x), .p(u5));
   thp_mul64 u_mul_u2 (.clock(clock), .en(en), .a(press_ofs), .b(p2x), .p(u2));

   // square terms
   logic [63:0] w2a, w1a;
   thp_mul64 u_mul_w2 (.clock(clock), .en(en), .a(sq), .b(p6x), .p(w2a));
   thp_mul64 u_mul_w1 (.clock(clock), .en(en), .a(sq), .b(p3x), .p(w1a));

   logic [19:0] ap_ff [5];
   logic [63:0] u5_ff [2];
   logic [63:0] u2_ff [2];
   logic [63:0] y_ff;
   logic [63:0] w2_ff;
   logic [63:0] n0_ff;
   logic [63:0] n_ff;
   logic [63:0] x;

   thp_mul64 u_mul_x (.clock(clock), .en(en), .a(y_ff), .b(p1z), .p(x));

   always_ff @(posedge clock) begin
      if (en) begin
         ap_ff[0] <= raw_press;
         for (int i = 1; i < 5; i++) begin
            ap_ff[i] <= ap_ff[i-1];
         end
         u5_ff[0] <= u5;
         u5_ff[1] <= u5_ff[0];
         u2_ff[0] <= u2;
         u2_ff[1] <= u2_ff[0];
         y_ff  <= thp_pkg::PRESS_ONE_47 + thp_pkg::asr64(w1a, 8) + (u2_ff[1] << 12);
         w2_ff <= w2a + (u5_ff[1] << 17) + (p4x << 35);
         n0_ff <= ((thp_pkg::PRESS_BASE - {44'd0, ap_ff[4]}) << 31) - w2_ff;
         n_ff  <= n0_ff * thp_pkg::PRESS_SCALE;
      end
   end

   // sign and magnitude ahead of the divider
   logic [63:0] den_full;
   logic [63:0] den_abs;
   logic [63:0] mn_ff;
   logic [30:0] md_ff;
   logic [1:0]  side_ff;

   assign den_full = thp_pkg::asr64(x, 33);
   assign den_abs  = den_full[63] ? 64'(-den_full) : den_full;

   always_ff @(posedge clock) begin
      if (en) begin
         mn_ff   <= n_ff[63] ? 64'(-n_ff) : n_ff;
         md_ff   <= den_abs[30:0];
         side_ff <= {n_ff[63] ^ den_full[63], den_full == 64'd0};
      end
   end

   logic [63:0] quo;
   logic [1:0]  side_q;

   thp_div u_div (
      .clock(clock), .en(en), .num(mn_ff), .den(md_ff), .side(side_ff),
      .quo(quo), .side_out(side_q)
   );

   logic [63:0] p_ff;
   logic        dz_ff [7];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= side_q[1] ? 64'(-quo) : quo;
         dz_ff[0] <= side_q[0];
         for (int i = 1; i < 7; i++) begin
            dz_ff[i] <= dz_ff[i-1];
         end
      end
   end

   // correction terms
   logic [63:0] ps;
   logic [63:0] m9, m8, x1m;
   logic [63:0] ps_ff [2];
   logic [63:0] m8_ff [2];
   logic [63:0] pd_ff [4];
   logic [63:0] sum_ff;
   logic [31:0] press_ff;

   assign ps = thp_pkg::asr64(p_ff, 13);

   thp_mul64 u_mul_m9  (.clock(clock), .en(en), .a(p9x), .b(ps), .p(m9));
   thp_mul64 u_mul_m8  (.clock(clock), .en(en), .a(p8x), .b(p_ff), .p(m8));
   thp_mul64 u_mul_x1  (.clock(clock), .en(en), .a(m9), .b(ps_ff[1]), .p(x1m));

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff[0] <= ps;
         ps_ff[1] <= ps_ff[0];
         m8_ff[0] <= m8;
         m8_ff[1] <= m8_ff[0];
         pd_ff[0] <= p_ff;
         for (int i = 1; i < 4; i++) begin
            pd_ff[i] <= pd_ff[i-1];
         end
         sum_ff   <= pd_ff[3] + thp_pkg::asr64(x1m, 25) + thp_pkg::asr64(m8_ff[1], 19);
         press_ff <= dz_ff[5] ? 32'd0
                              : 32'(thp_pkg::asr64(sum_ff, 8) + (p7x << 4));
      end
   end

   assign press_q24_8    = press_ff;
   assign press_div_zero = dz_ff[6];

endmodule

// ===== hdl/thp_hum.sv =====
// humidity stages: 32-bit wrapping formula and clamp to 0..100 %RH
// depends on thp_pkg

module thp_hum (
   input  logic                  clock,
   input  logic                  en,
   input  thp_pkg::thp_trim_type trim,
   input  logic [31:0]           hum_ofs,
   input  logic [15:0]           raw_hum,
   output logic [16:0]           hum_q22_10
);

   logic [31:0] h1z, h2x, h3z, h4x, h5x, h6x;

   assign h1z = {24'd0, trim.h1};
   assign h2x = thp_pkg::sx32_16(trim.h2);
   assign h3z = {24'd0, trim.h3};
   assign h4x = thp_pkg::sx32_12(trim.h4);
   assign h5x = thp_pkg::sx32_12(trim.h5);
   assign h6x = thp_pkg::sx32_8(trim.h6);

   logic [31:0] hm5_ff, vh6_ff, vh3_ff;
   logic [15:0] ah_ff;
   logic [31:0] xs_ff [5];
   logic [31:0] a6_ff, b3_ff;
   logic [31:0] y0_ff, y1_ff, y2_ff, y3_ff;
   logic [31:0] vv_ff [3];
   logic [31:0] vsq_ff;
   logic [31:0] t_ff;
   logic [16:0] hum_ff;
   logic [31:0] vs;
   logic [31:0] r;

   assign vs = thp_pkg::asr32(vv_ff[0], 15);
   assign r  = vv_ff[2] - thp_pkg::asr32(t_ff, 4);

   always_ff @(posedge clock) begin
      if (en) begin
         hm5_ff <= hum_ofs * h5x;
         vh6_ff <= hum_ofs * h6x;
         vh3_ff <= hum_ofs * h3z;
         ah_ff  <= raw_hum;
         xs_ff[0] <= thp_pkg::asr32(({16'd0, ah_ff} << 14) - (h4x << 20) - hm5_ff
                                    + thp_pkg::HUM_ROUND_X, 15);
         for (int i = 1; i < 5; i++) begin
            xs_ff[i] <= xs_ff[i-1];
         end
         a6_ff <= thp_pkg::asr32(vh6_ff, 10);
         b3_ff <= thp_pkg::asr32(vh3_ff, 11) + thp_pkg::HUM_BIAS_H3;
         y0_ff <= a6_ff * b3_ff;
         y1_ff <= thp_pkg::asr32(y0_ff, 10) + thp_pkg::HUM_BIAS_Y;
         y2_ff <= y1_ff * h2x;
         y3_ff <= thp_pkg::asr32(y2_ff + thp_pkg::HUM_ROUND_Y, 14);
         vv_ff[0] <= xs_ff[4] * y3_ff;
         vv_ff[1] <= vv_ff[0];
         vv_ff[2] <= vv_ff[1];
         vsq_ff <= vs * vs;
         t_ff   <= thp_pkg::asr32(vsq_ff, 7) * h1z;
         // clamp below zero and above full scale before dropping 12 bits
         if (r[31]) begin
            hum_ff <= 17'd0;
         end else if (r > thp_pkg::HUM_MAX) begin
            hum_ff <= thp_pkg::HUM_MAX[28:12];
         end else begin
            hum_ff <= r[28:12];
         end
      end
   end

   assign hum_q22_10 = hum_ff;

endmodule

// ===== hdl/thp_sensor_compensation_unit.sv =====
// Temperature, pressure and humidity compensation engine. One raw triple
// enters on the req_ stream, one compensated item leaves on the rsp_ stream.
// The unit is a fully pipelined datapath that takes a new item every cycle
// while the pipe advances; each item passes the 64-stage pressure divider
// plus the multiplier stages around it. The whole pipe advances together:
// it moves whenever the output stage is empty or being taken, so a stalled
// result holds every stage in place. Trim words are loaded through the csr_
// port (index 0..5 in the order temp, press a/b/c, hum a/b) and must only
// change while no item is in flight. A zero pressure divisor gives pressure 0
// with the div-zero flag set in rsp_tuser.
// depends on thp_pkg, thp_temp, thp_press, thp_hum

module thp_sensor_compensation_unit (
   input  logic                                clock,
   input  logic                                reset,
   // raw_temp [19:0], raw_press [39:20], raw_hum [55:40]
   input  logic [55:0]                         req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // temp_centideg [31:0], press_q24_8 [63:32], hum_q22_10 [80:64], zero pad
   output logic [87:0]                         rsp_tdata,
   // press_div_zero [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [thp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [thp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int TOTAL_LAT = thp_pkg::TOTAL_LAT;
   localparam int TEMP_DLY  = thp_pkg::PRESS_LAT;
   localparam int HUM_DLY   = thp_pkg::PRESS_LAT - thp_pkg::HUM_LAT;

   // trim registers
   logic [47:0] temp_trim_ff;
   logic [47:0] press_a_ff;
   logic [47:0] press_b_ff;
   logic [47:0] press_c_ff;
   logic [31:0] hum_a_ff;
   logic [31:0] hum_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
         hum_a_ff     <= '0;
         hum_b_ff     <= '0;
      end else if (csr_valid) begin
         unique case (thp_pkg::thp_csr_type'(csr_index))
            thp_pkg::CSR_TEMP_TRIM:    temp_trim_ff <= csr_data;
            thp_pkg::CSR_PRESS_TRIM_A: press_a_ff   <= csr_data;
            thp_pkg::CSR_PRESS_TRIM_B: press_b_ff   <= csr_data;
            thp_pkg::CSR_PRESS_TRIM_C: press_c_ff   <= csr_data;
            thp_pkg::CSR_HUM_TRIM_A:   hum_a_ff     <= csr_data[31:0];
            thp_pkg::CSR_HUM_TRIM_B:   hum_b_ff     <= csr_data[31:0];
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   // split trim words
   thp_pkg::thp_trim_type trim;

   always_comb begin
      trim.t1 = temp_trim_ff[15:0];
      trim.t2 = temp_trim_ff[31:16];
      trim.t3 = temp_trim_ff[47:32];
      trim.p1 = press_a_ff[15:0];
      trim.p2 = press_a_ff[31:16];
      trim.p3 = press_a_ff[47:32];
      trim.p4 = press_b_ff[15:0];
      trim.p5 = press_b_ff[31:16];
      trim.p6 = press_b_ff[47:32];
      trim.p7 = press_c_ff[15:0];
      trim.p8 = press_c_ff[31:16];
      trim.p9 = press_c_ff[47:32];
      trim.h1 = hum_a_ff[7:0];
      trim.h2 = hum_a_ff[23:8];
      trim.h3 = hum_a_ff[31:24];
      trim.h4 = hum_b_ff[11:0];
      trim.h5 = hum_b_ff[23:12];
      trim.h6 = hum_b_ff[31:24];
   end

   // global advance: the pipe moves when the output stage is free or taken
   logic                 adv;
   logic [TOTAL_LAT-1:0] vld_ff;

   assign adv        = ~vld_ff[TOTAL_LAT-1] | rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   // temperature front end, feeds both other paths
   logic [31:0] temp_c;
   logic [63:0] press_ofs;
   logic [31:0] hum_ofs;
   logic [19:0] raw_press_d;
   logic [15:0] raw_hum_d;

   thp_temp u_temp (
      .clock         (clock),
      .en            (adv),
      .trim          (trim),
      .raw_temp      (req_tdata[19:0]),
      .raw_press     (req_tdata[39:20]),
      .raw_hum       (req_tdata[55:40]),
      .temp_centideg (temp_c),
      .press_ofs     (press_ofs),
      .hum_ofs       (hum_ofs),
      .raw_press_d   (raw_press_d),
      .raw_hum_d     (raw_hum_d)
   );

   logic [31:0] press_q;
   logic        press_dz;

   thp_press u_press (
      .clock          (clock),
      .en             (adv),
      .trim           (trim),
      .press_ofs      (press_ofs),
      .raw_press      (raw_press_d),
      .press_q24_8    (press_q),
      .press_div_zero (press_dz)
   );

   logic [16:0] hum_q;

   thp_hum u_hum (
      .clock      (clock),
      .en         (adv),
      .trim       (trim),
      .hum_ofs    (hum_ofs),
      .raw_hum    (raw_hum_d),
      .hum_q22_10 (hum_q)
   );

   // shift lines that line the short paths up with the pressure result
   logic [31:0] temp_dly_ff [TEMP_DLY];
   logic [16:0] hum_dly_ff  [HUM_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         temp_dly_ff[0] <= temp_c;
         for (int i = 1; i < TEMP_DLY; i++) begin
            temp_dly_ff[i] <= temp_dly_ff[i-1];
         end
         hum_dly_ff[0] <= hum_q;
         for (int i = 1; i < HUM_DLY; i++) begin
            hum_dly_ff[i] <= hum_dly_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];
   assign rsp_tdata  = {7'd0, hum_dly_ff[HUM_DLY-1], press_q, temp_dly_ff[TEMP_DLY-1]};
   assign rsp_tuser  = press_dz;

endmodule

// ===== tb/tb_thp_sensor_compensation_unit.sv =====
// testbench of the thp sensor compensation unit: directed table then random raw triples,
// every result checked against typed-in values or an in-bench compensation predictor
// depends on thp_pkg and thp_sensor_compensation_unit
`timescale 1ns / 100ps

module tb_thp_sensor_compensation_unit;

   localparam int CYCLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [31:0] temp_centideg;
      logic [31:0] press_q24_8;
      logic [16:0] hum_q22_10;
      logic        press_div_zero;
   } comp_result_type;

   typedef struct {
      logic [19:0] raw_temp;
      logic [19:0] raw_press;
      logic [15:0] raw_hum;
      bit          fixed;     // expected result typed in below
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
      logic        dz;
   } raw_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [55:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [87:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [thp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [thp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // local copy of trim registers
   logic [47:0] trim_reg [0:5];

   comp_result_type expected_results [$];
   int fail_count = 0;
   int cycle_count = 0;
   bit idle_free = 1'b0;   // disables random request idling and receiver stalls during a stretch

   thp_sensor_compensation_unit u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] sra32(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] sra64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   // signed divide truncating toward zero, wrapping on overflow
   function automatic logic [63:0] div_trunc64(logic [63:0] n, logic [63:0] d);
      logic [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   // compute the compensated triple from the current trim copy
   function automatic comp_result_type compensate(logic [19:0] rt, logic [19:0] rp,
                                                  logic [15:0] rh);
      comp_result_type r;
      logic [31:0] t1, t2, t3, a, v1, d, v2, tfine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, ps, x1, x2;
      logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, vs;
      t1 = {16'd0, trim_reg[thp_pkg::CSR_TEMP_TRIM][15:0]};
      t2 = {{16{trim_reg[thp_pkg::CSR_TEMP_TRIM][31]}},
            trim_reg[thp_pkg::CSR_TEMP_TRIM][31:16]};
      t3 = {{16{trim_reg[thp_pkg::CSR_TEMP_TRIM][47]}},
            trim_reg[thp_pkg::CSR_TEMP_TRIM][47:32]};
      a = {15'd0, rt[19:3]} - (t1 << 1);
      v1 = sra32(a * t2, 11);
      d = {16'd0, rt[19:4]} - t1;
      v2 = sra32(sra32(d * d, 12) * t3, 14);
      tfine = v1 + v2;
      r.temp_centideg = sra32(tfine * 32'd5 + 32'd128, 8);

      // pressure path, 64-bit wrap
      p1 = {48'd0, trim_reg[thp_pkg::CSR_PRESS_TRIM_A][15:0]};
      p2 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_A][31]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_A][31:16]};
      p3 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_A][47]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_A][47:32]};
      p4 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_B][15]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_B][15:0]};
      p5 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_B][31]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_B][31:16]};
      p6 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_B][47]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_B][47:32]};
      p7 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_C][15]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_C][15:0]};
      p8 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_C][31]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_C][31:16]};
      p9 = {{48{trim_reg[thp_pkg::CSR_PRESS_TRIM_C][47]}},
            trim_reg[thp_pkg::CSR_PRESS_TRIM_C][47:32]};
      w1 = {{32{tfine[31]}}, tfine} - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
      w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
      r.press_q24_8 = '0;
      r.press_div_zero = (w1 == 64'd0);
      if (!r.press_div_zero) begin
         p = 64'd1048576 - {44'd0, rp};
         p = div_trunc64(((p << 31) - w2) * 64'd3125, w1);
         ps = sra64(p, 13);
         x1 = sra64(p9 * ps * ps, 25);
         x2 = sra64(p8 * p, 19);
         p = sra64(p + x1 + x2, 8) + (p7 << 4);
         r.press_q24_8 = p[31:0];
      end

      // humidity path, 32-bit wrap
      h1 = {24'd0, trim_reg[thp_pkg::CSR_HUM_TRIM_A][7:0]};
      h2 = {{16{trim_reg[thp_pkg::CSR_HUM_TRIM_A][23]}},
            trim_reg[thp_pkg::CSR_HUM_TRIM_A][23:8]};
      h3 = {24'd0, trim_reg[thp_pkg::CSR_HUM_TRIM_A][31:24]};
      h4 = {{20{trim_reg[thp_pkg::CSR_HUM_TRIM_B][11]}},
            trim_reg[thp_pkg::CSR_HUM_TRIM_B][11:0]};
      h5 = {{20{trim_reg[thp_pkg::CSR_HUM_TRIM_B][23]}},
            trim_reg[thp_pkg::CSR_HUM_TRIM_B][23:12]};
      h6 = {{24{trim_reg[thp_pkg::CSR_HUM_TRIM_B][31]}},
            trim_reg[thp_pkg::CSR_HUM_TRIM_B][31:24]};
      v = tfine - 32'd76800;
      x = sra32(({16'd0, rh} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
      y = sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768);
      y = sra32(y, 10) + 32'd2097152;
      y = sra32(y * h2 + 32'd8192, 14);
      v = x * y;
      vs = sra32(v, 15);
      v = v - sra32(sra32(vs * vs, 7) * h1, 4);
      if (v[31]) v = '0;
      if (v > 32'd419430400) v = 32'd419430400;
      r.hum_q22_10 = v[28:12];
      return r;
   endfunction

   // random idle cycles on the request side, valid drops while idling
   task automatic idle_gap();
      while (!idle_free && $urandom_range(99) < 12) begin
         if (req_tvalid) req_tvalid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic write_trim(thp_pkg::thp_csr_type idx, logic [47:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      trim_reg[idx] = (idx >= thp_pkg::CSR_HUM_TRIM_A) ? {16'd0, value[31:0]} : value;
      @(negedge clock);
   endtask

   // send one raw triple; the expectation is queued when it is accepted
   task automatic send_raw(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                           bit fixed = 0, comp_result_type typed = '{default: '0});
      comp_result_type r;
      idle_gap();
      req_tdata <= {rh, rp, rt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = fixed ? typed : compensate(rt, rp, rh);
      expected_results.push_back(r);
      @(negedge clock);
   endtask

   // wait for every result, then wait DRAIN_CYCLES as well, before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver: random stall
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= idle_free || ($urandom_range(99) >= 12);
   end

   // result checker
   always @(posedge clock) begin
      comp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected item on rsp");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.temp_centideg) begin
               $error("temp_centideg expected %h actual %h", want.temp_centideg,
                      rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.press_q24_8) begin
               $error("press_q24_8 expected %h actual %h", want.press_q24_8,
                      rsp_tdata[63:32]);
               fail_count++;
            end
            if (rsp_tdata[80:64] !== want.hum_q22_10) begin
               $error("hum_q22_10 expected %h actual %h", want.hum_q22_10,
                      rsp_tdata[80:64]);
               fail_count++;
            end
            if (rsp_tuser !== want.press_div_zero) begin
               $error("press_div_zero expected %b actual %b", want.press_div_zero,
                      rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // plausible factory trim set, so the random part hits normal pressures
   task automatic load_typical_trim();
      write_trim(thp_pkg::CSR_TEMP_TRIM, {16'hFFE0 + 16'($urandom_range(63)),
                                          16'd26000 + 16'($urandom_range(2000)),
                                          16'd27000 + 16'($urandom_range(2000))});
      write_trim(thp_pkg::CSR_PRESS_TRIM_A, {16'd3024 + 16'($urandom_range(100)),
                                             16'hD600 + 16'($urandom_range(255)),
                                             16'd36000 + 16'($urandom_range(2000))});
      write_trim(thp_pkg::CSR_PRESS_TRIM_B, {16'hFF80 + 16'($urandom_range(127)),
                                             16'd100 + 16'($urandom_range(400)),
                                             16'd6000 + 16'($urandom_range(3000))});
      write_trim(thp_pkg::CSR_PRESS_TRIM_C, {16'd6000 + 16'($urandom_range(2000)),
                                             16'hC000 + 16'($urandom_range(255)),
                                             16'd15500 + 16'($urandom_range(500))});
      write_trim(thp_pkg::CSR_HUM_TRIM_A, {8'd0, 16'd360 + 16'($urandom_range(40)),
                                           8'd75});
      write_trim(thp_pkg::CSR_HUM_TRIM_B, {8'd30, 12'd50, 12'd320});
   endtask

   // directed rows: the first three, extremes with all trims zero, give known results
   raw_row_type directed_rows [] = '{
      '{20'h00000, 20'h00000, 16'h0000, 1, 32'd0, 32'd0, 17'd0, 1'b1},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, 32'd0, 32'd0, 17'd0, 1'b1},
      '{20'h80000, 20'h55555, 16'hAAAA, 1, 32'd0, 32'd0, 17'd0, 1'b1},
      '{20'h7FFFF, 20'hAAAAA, 16'h5555, 0, 0, 0, 0, 0},
      '{20'h00000, 20'h00000, 16'h0000, 0, 0, 0, 0, 0},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, 0, 0, 0, 0},
      '{20'd519888, 20'd415148, 16'd27000, 0, 0, 0, 0, 0},
      '{20'd400000, 20'd300000, 16'd60000, 0, 0, 0, 0, 0},
      '{20'd600000, 20'd500000, 16'd1000, 0, 0, 0, 0, 0},
      '{20'h55555, 20'h00001, 16'h8000, 0, 0, 0, 0, 0}
   };

   initial begin
      comp_result_type typed;
      for (int i = 0; i < 6; i++) trim_reg[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: divisor zero, everything else zero
      for (int i = 0; i < 3; i++) begin
         typed = '{directed_rows[i].temp, directed_rows[i].press,
                   directed_rows[i].hum, directed_rows[i].dz};
         send_raw(directed_rows[i].raw_temp, directed_rows[i].raw_press,
                  directed_rows[i].raw_hum, 1'b1, typed);
      end
      drain();

      // typical trim set, then all-ones and alternating extremes
      load_typical_trim();
      for (int i = 3; i < directed_rows.size(); i++)
         send_raw(directed_rows[i].raw_temp, directed_rows[i].raw_press,
                  directed_rows[i].raw_hum);
      drain();
      for (int i = 0; i < 6; i++) write_trim(thp_pkg::thp_csr_type'(i), '1);
      for (int i = 3; i < directed_rows.size(); i++)
         send_raw(directed_rows[i].raw_temp, directed_rows[i].raw_press,
                  directed_rows[i].raw_hum);
      drain();
      // p1 = 0 forces a zero divisor with non-zero other trims
      write_trim(thp_pkg::CSR_PRESS_TRIM_A, 48'h8000_7FFF_0000);
      for (int i = 3; i < 6; i++)
         send_raw(directed_rows[i].raw_temp, directed_rows[i].raw_press,
                  directed_rows[i].raw_hum);
      drain();

      // random phases: mostly typical trims, some fully random ones
      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 4 == 3) begin
            for (int i = 0; i < 6; i++)
               write_trim(thp_pkg::thp_csr_type'(i), 48'({$urandom, $urandom}));
         end else begin
            load_typical_trim();
         end
         idle_free = (phase == 5);
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(3) == 0)
               send_raw(20'($urandom), 20'($urandom), 16'($urandom));
            else
               send_raw(20'd380000 + 20'($urandom_range(280000)),
                        20'd250000 + 20'($urandom_range(250000)),
                        16'd15000 + 16'($urandom_range(40000)));
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
